// ===== hdl/i2cms_pkg.sv =====
// Shared types and constants for the I2C master transfer sequencer.
`default_nettype none

package i2cms_pkg;

  // Operation carried on the input stream's tuser
  typedef enum logic [1:0] {
    OP_LOAD_DESC = 2'd0,
    OP_LOAD_TX   = 2'd1,
    OP_START     = 2'd2,
    OP_EVENT     = 2'd3
  } op_t;

  // Controller status codes
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
  localparam logic [7:0] ST_TXDATA_ACK  = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
  localparam logic [7:0] ST_RXDATA_ACK  = 8'h50;
  localparam logic [7:0] ST_RXDATA_NACK = 8'h58;

  // Transfer outcome codes
  localparam logic [1:0] OUTC_BUSY = 2'd0;
  localparam logic [1:0] OUTC_DONE = 2'd1;
  localparam logic [1:0] OUTC_FAIL = 2'd2;

  localparam int LEN_W = 9;

  typedef struct packed {
    op_t         op;
    logic [2:0]  msg_slot;
    logic [7:0]  byte_slot;
    logic        is_read;
    logic [8:0]  msg_length;
    logic [7:0]  data_byte;
    logic [6:0]  chip_address;
    logic [3:0]  message_count;
    logic [7:0]  status_code;
    logic        timed_out;
  } item_t;

  typedef struct packed {
    logic             rd;
    logic [LEN_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic       ctl_start;
    logic       ctl_stop;
    logic       ctl_ack;
    logic       ctl_clear_flag;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [2:0] rx_msg;
    logic [7:0] rx_pos;
    logic [7:0] rx_byte;
    logic [1:0] outcome;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/i2cms_store.sv =====
// Descriptor table and transmit buffer memories with registered reads.
`default_nettype none

module i2cms_store #(
  parameter int MAX_MSGS  = 8,
  parameter int MAX_BYTES = 256
) (
  input  wire logic                         clk,
  input  wire logic                         take_i,
  input  wire i2cms_pkg::item_t             item_i,
  input  wire logic [$clog2(MAX_MSGS+1)-1:0] cur_i,
  input  wire logic [i2cms_pkg::LEN_W-1:0]  pos_i,
  output i2cms_pkg::desc_t                  desc_q_o,
  output logic [7:0]                        tx_q_o
);

  localparam int MSG_W    = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
  localparam int TX_DEPTH = MAX_MSGS * MAX_BYTES;
  localparam int TXA_W    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  i2cms_pkg::desc_t desc_mem [MAX_MSGS];
  logic [7:0]       tx_mem   [TX_DEPTH];

  i2cms_pkg::desc_t desc_q_r;
  logic [7:0]       tx_q_r;

  logic                         slot_ok;
  logic                         byte_ok;
  logic                         desc_we;
  logic                         tx_we;
  logic                         rd_en;
  logic [MSG_W-1:0]             desc_wa;
  logic [MSG_W-1:0]             desc_ra;
  logic [TXA_W-1:0]             tx_wa;
  logic [TXA_W-1:0]             tx_ra;
  i2cms_pkg::desc_t             desc_wd;

  assign slot_ok = ({29'd0, item_i.msg_slot} < 32'(MAX_MSGS));
  assign byte_ok = ({24'd0, item_i.byte_slot} < 32'(MAX_BYTES));
  assign desc_we = take_i && (item_i.op == i2cms_pkg::OP_LOAD_DESC) && slot_ok;
  assign tx_we   = take_i && (item_i.op == i2cms_pkg::OP_LOAD_TX) && slot_ok && byte_ok;
  assign rd_en   = take_i && (item_i.op == i2cms_pkg::OP_EVENT);

  assign desc_wa = MSG_W'(item_i.msg_slot);
  assign desc_ra = cur_i[MSG_W-1:0];

  // Saturate the message length at the buffer size
  always_comb begin
    desc_wd.rd  = item_i.is_read;
    desc_wd.len = ({23'd0, item_i.msg_length} > 32'(MAX_BYTES)) ?
                  i2cms_pkg::LEN_W'(MAX_BYTES) : item_i.msg_length;
  end

  assign tx_wa = TXA_W'(32'(item_i.msg_slot) * 32'(MAX_BYTES) + 32'(item_i.byte_slot));
  assign tx_ra = TXA_W'(32'(desc_ra) * 32'(MAX_BYTES) + 32'(pos_i));

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_wa] <= desc_wd;
    end
    if (rd_en) begin
      desc_q_r <= desc_mem[desc_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wa] <= item_i.data_byte;
    end
    if (rd_en) begin
      tx_q_r <= tx_mem[tx_ra];
    end
  end

  assign desc_q_o = desc_q_r;
  assign tx_q_o   = tx_q_r;

endmodule

`default_nettype wire

// ===== hdl/i2cms_ctrl.sv =====
// Sequencer state, per-event decision stage and result register.
`default_nettype none

module i2cms_ctrl #(
  parameter int MAX_MSGS  = 8,
  parameter int MAX_BYTES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take_i,
  input  wire i2cms_pkg::item_t              item_i,
  input  wire i2cms_pkg::desc_t              desc_i,
  input  wire logic [7:0]                    tx_i,
  output logic                               busy_o,
  output logic [$clog2(MAX_MSGS+1)-1:0]      cur_o,
  output logic [i2cms_pkg::LEN_W-1:0]        pos_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output i2cms_pkg::result_t                 out_res_o
);

  localparam int CNT_W = $clog2(MAX_MSGS + 1);
  localparam int LW    = i2cms_pkg::LEN_W;

  logic                b_valid_r, b_valid_nxt;
  i2cms_pkg::item_t    b_item_r;
  logic [6:0]          addr_r, addr_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    cur_r, cur_nxt;
  logic [LW-1:0]       pos_r, pos_nxt;
  logic                active_r, active_nxt;
  logic                out_valid_r, out_valid_nxt;
  i2cms_pkg::result_t  out_res_r;

  i2cms_pkg::result_t  res;
  logic                res_valid;
  logic                do_fail;
  logic                do_adv;
  logic                b_done;
  logic                cnt_ok;

  assign cnt_ok = (b_item_r.message_count != 4'd0) &&
                  ({28'd0, b_item_r.message_count} <= 32'(MAX_MSGS));

  always_comb begin
    res        = '0;
    res_valid  = 1'b0;
    do_fail    = 1'b0;
    do_adv     = 1'b0;
    addr_nxt   = addr_r;
    total_nxt  = total_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    active_nxt = active_r;
    unique case (b_item_r.op)
      i2cms_pkg::OP_LOAD_DESC, i2cms_pkg::OP_LOAD_TX: begin
      end
      i2cms_pkg::OP_START: begin
        if (cnt_ok) begin
          addr_nxt      = b_item_r.chip_address;
          total_nxt     = CNT_W'(b_item_r.message_count);
          cur_nxt       = '0;
          pos_nxt       = '0;
          active_nxt    = 1'b1;
          res_valid     = 1'b1;
          res.ctl_start = 1'b1;
        end
      end
      i2cms_pkg::OP_EVENT: begin
        if (active_r) begin
          res_valid = 1'b1;
          if (b_item_r.timed_out) begin
            do_fail = 1'b1;
          end else if (desc_i.rd) begin
            unique case (b_item_r.status_code)
              i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
                res.tx_valid       = 1'b1;
                res.tx_byte        = {addr_r, 1'b1};
                res.ctl_clear_flag = 1'b1;
              end
              i2cms_pkg::ST_SLAR_ACK: begin
                if (desc_i.len == '0) begin
                  do_fail = 1'b1;
                end else begin
                  res.ctl_clear_flag = 1'b1;
                  res.ctl_ack        = (desc_i.len > LW'(1));
                end
              end
              i2cms_pkg::ST_RXDATA_ACK, i2cms_pkg::ST_RXDATA_NACK: begin
                // Store the byte unless the message is already full
                if (pos_r < desc_i.len) begin
                  res.rx_valid = 1'b1;
                  res.rx_msg   = 3'(cur_r);
                  res.rx_pos   = pos_r[7:0];
                  res.rx_byte  = b_item_r.data_byte;
                  pos_nxt      = pos_r + LW'(1);
                end
                if (b_item_r.status_code == i2cms_pkg::ST_RXDATA_ACK) begin
                  res.ctl_clear_flag = 1'b1;
                  res.ctl_ack = ({1'b0, pos_nxt} + (LW+1)'(1)) < {1'b0, desc_i.len};
                end else begin
                  do_adv = 1'b1;
                end
              end
              default: do_fail = 1'b1;
            endcase
          end else begin
            unique case (b_item_r.status_code)
              i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
                res.tx_valid       = 1'b1;
                res.tx_byte        = {addr_r, 1'b0};
                res.ctl_clear_flag = 1'b1;
              end
              i2cms_pkg::ST_SLAW_ACK, i2cms_pkg::ST_TXDATA_ACK: begin
                if ((pos_r < desc_i.len) && ({23'd0, pos_r} < 32'(MAX_BYTES))) begin
                  res.tx_valid       = 1'b1;
                  res.tx_byte        = tx_i;
                  res.ctl_clear_flag = 1'b1;
                  pos_nxt            = pos_r + LW'(1);
                end else begin
                  do_adv = 1'b1;
                end
              end
              default: do_fail = 1'b1;
            endcase
          end
        end
      end
    endcase

    // Move on to the next message, or finish the transfer
    if (do_adv) begin
      cur_nxt            = cur_r + CNT_W'(1);
      res.ctl_clear_flag = 1'b1;
      if (cur_nxt < total_r) begin
        pos_nxt       = '0;
        res.ctl_start = 1'b1;
      end else begin
        res.ctl_stop = 1'b1;
        res.outcome  = i2cms_pkg::OUTC_DONE;
        active_nxt   = 1'b0;
      end
    end

    if (do_fail) begin
      res.ctl_stop       = 1'b1;
      res.ctl_clear_flag = 1'b1;
      res.outcome        = i2cms_pkg::OUTC_FAIL;
      active_nxt         = 1'b0;
    end
  end

  // Retire the decision stage once its result has somewhere to go
  assign b_done = b_valid_r && (!res_valid || !out_valid_r || out_ready_i);

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (b_done) begin
      b_valid_nxt = 1'b0;
    end
    if (take_i && ((item_i.op == i2cms_pkg::OP_START) || (item_i.op == i2cms_pkg::OP_EVENT))) begin
      b_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end
    if (b_done && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      total_r     <= '0;
      cur_r       <= '0;
      pos_r       <= '0;
      active_r    <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (b_done) begin
        addr_r   <= addr_nxt;
        total_r  <= total_nxt;
        cur_r    <= cur_nxt;
        pos_r    <= pos_nxt;
        active_r <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_i) begin
      b_item_r <= item_i;
    end
    if (b_done && res_valid) begin
      out_res_r <= res;
    end
  end

  assign busy_o      = b_valid_r;
  assign cur_o       = cur_r;
  assign pos_o       = pos_r;
  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_res_r;

`ifndef ASSERT_OFF
  a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cur_r < total_r))
    else $error("current message beyond message count while active");

  a_end_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
    (b_done && res_valid && (res.outcome != i2cms_pkg::OUTC_BUSY)) |=> !active_r)
    else $error("transfer ended but still active");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_done) |=> (b_valid_r && $stable(b_item_r)))
    else $error("stalled decision stage lost its item");

  a_no_start_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.ctl_start && out_res_r.ctl_stop))
    else $error("start and stop requested together");
`endif

endmodule

`default_nettype wire

// ===== hdl/i2c_master_transfer_sequencer_top.sv =====
// Top level of the I2C master transfer sequencer.
//
// Channel | Direction | Handshake           | Content
// in_     | slave     | in_tvalid/in_tready | tuser op, tdata descriptor/byte/start/event
// out_    | master    | out_tvalid/out_tready | tdata control action and rx placement
//
// Descriptor and transmit-byte loads do not stall the input and yield no result.
// A bus event reads the memories at the transfer edge (synchronous read). A start
// or event then decides in the decision stage and updates the sequencer state;
// in_tready stays low until that stage retires, which a full output can delay.
// Reset clears the sequencer state and valid flags only; the memories are not
// cleared. A result waiting in the output register does not block the input
// while the decision stage is free.
`default_nettype none

module i2c_master_transfer_sequencer_top #(
  parameter int MAX_MSGS  = 8,
  parameter int MAX_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: msg_slot[2:0] byte_slot[10:3] is_read[11] msg_length[20:12]
  //        data_byte[28:21] chip_address[35:29] message_count[39:36]
  //        status_code[47:40] timed_out[48], zero above
  input  wire logic [55:0] in_tdata,
  // tuser: op[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: ctl_start[0] ctl_stop[1] ctl_ack[2] ctl_clear_flag[3] tx_valid[4]
  //        tx_byte[12:5] rx_valid[13] rx_msg[16:14] rx_pos[24:17]
  //        rx_byte[32:25] outcome[34:33], zero above
  output logic [39:0]      out_tdata
);

  localparam int CNT_W = $clog2(MAX_MSGS + 1);

  i2cms_pkg::item_t   item;
  i2cms_pkg::desc_t   desc_q;
  i2cms_pkg::result_t res;
  logic [7:0]         tx_q;
  logic               take;
  logic               busy;
  logic [CNT_W-1:0]   cur;
  logic [i2cms_pkg::LEN_W-1:0] pos;

  // Unpack the input transfer
  always_comb begin
    item.op            = i2cms_pkg::op_t'(in_tuser);
    item.msg_slot      = in_tdata[2:0];
    item.byte_slot     = in_tdata[10:3];
    item.is_read       = in_tdata[11];
    item.msg_length    = in_tdata[20:12];
    item.data_byte     = in_tdata[28:21];
    item.chip_address  = in_tdata[35:29];
    item.message_count = in_tdata[39:36];
    item.status_code   = in_tdata[47:40];
    item.timed_out     = in_tdata[48];
  end

  // Hold off new transfers while a start or event sits in the decision stage
  assign in_tready = !busy;
  assign take      = in_tvalid && in_tready;

  i2cms_store #(
    .MAX_MSGS  (MAX_MSGS),
    .MAX_BYTES (MAX_BYTES)
  ) u_store (
    .clk      (clk),
    .take_i   (take),
    .item_i   (item),
    .cur_i    (cur),
    .pos_i    (pos),
    .desc_q_o (desc_q),
    .tx_q_o   (tx_q)
  );

  i2cms_ctrl #(
    .MAX_MSGS  (MAX_MSGS),
    .MAX_BYTES (MAX_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_i      (take),
    .item_i      (item),
    .desc_i      (desc_q),
    .tx_i        (tx_q),
    .busy_o      (busy),
    .cur_o       (cur),
    .pos_o       (pos),
    .out_ready_i (out_tready),
    .out_valid_o (out_tvalid),
    .out_res_o   (res)
  );

  // Pack the result transfer
  assign out_tdata = {5'd0, res.outcome, res.rx_byte, res.rx_pos, res.rx_msg,
                      res.rx_valid, res.tx_byte, res.tx_valid, res.ctl_clear_flag,
                      res.ctl_ack, res.ctl_stop, res.ctl_start};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking stream testbench for the I2C master transfer sequencer.
`timescale 1ns / 1ps

import i2cms_pkg::*;

class seq_action_scoreboard;
  localparam int MSG_SLOTS = 8;
  localparam int MSG_BYTES = 256;

  desc_t      desc_mem [MSG_SLOTS];
  logic [7:0] tx_mem   [MSG_SLOTS][MSG_BYTES];
  logic [6:0] chip;
  int         n_msgs;
  int         msg_idx;
  int         pos;
  bit         running;
  result_t    expected_actions[$];
  int         mismatch_count;

  function void fail_sequence(inout result_t r);
    r.ctl_stop       = 1'b1;
    r.ctl_clear_flag = 1'b1;
    r.outcome        = OUTC_FAIL;
    running          = 1'b0;
  endfunction

  // Restart into the next message, or stop after the last one
  function void next_message(inout result_t r);
    msg_idx++;
    r.ctl_clear_flag = 1'b1;
    if (msg_idx < n_msgs) begin
      pos         = 0;
      r.ctl_start = 1'b1;
    end else begin
      r.ctl_stop = 1'b1;
      r.outcome  = OUTC_DONE;
      running    = 1'b0;
    end
  endfunction

  function void place_rx(inout result_t r, input int len, input logic [7:0] b);
    if (pos < len) begin
      r.rx_valid = 1'b1;
      r.rx_msg   = msg_idx[2:0];
      r.rx_pos   = pos[7:0];
      r.rx_byte  = b;
      pos++;
    end
  endfunction

  // Work out the action for one accepted input; returns 0 if the block ignores it
  function bit note_transfer(item_t it);
    result_t r;
    desc_t   d;
    r = '0;
    case (it.op)
      OP_LOAD_DESC: begin
        desc_mem[it.msg_slot].rd  = it.is_read;
        desc_mem[it.msg_slot].len = (it.msg_length > MSG_BYTES) ? 9'(MSG_BYTES) : it.msg_length;
        return 1'b1;
      end
      OP_LOAD_TX: begin
        tx_mem[it.msg_slot][it.byte_slot] = it.data_byte;
        return 1'b1;
      end
      OP_START: begin
        if (it.message_count == 0 || it.message_count > MSG_SLOTS) return 1'b0;
        chip        = it.chip_address;
        n_msgs      = it.message_count;
        msg_idx     = 0;
        pos         = 0;
        running     = 1'b1;
        r.ctl_start = 1'b1;
      end
      default: begin
        if (!running) return 1'b0;
        if (it.timed_out || msg_idx >= MSG_SLOTS) begin
          fail_sequence(r);
        end else begin
          d = desc_mem[msg_idx];
          if (d.rd) begin
            if (it.status_code == ST_START || it.status_code == ST_RESTART) begin
              r.tx_valid       = 1'b1;
              r.tx_byte        = {chip, 1'b1};
              r.ctl_clear_flag = 1'b1;
            end else if (it.status_code == ST_SLAR_ACK) begin
              if (d.len == 0) begin
                fail_sequence(r);
              end else begin
                r.ctl_clear_flag = 1'b1;
                r.ctl_ack        = (d.len > 1);
              end
            end else if (it.status_code == ST_RXDATA_ACK) begin
              place_rx(r, d.len, it.data_byte);
              r.ctl_clear_flag = 1'b1;
              r.ctl_ack        = (pos + 1 < d.len);
            end else if (it.status_code == ST_RXDATA_NACK) begin
              place_rx(r, d.len, it.data_byte);
              next_message(r);
            end else begin
              fail_sequence(r);
            end
          end else begin
            if (it.status_code == ST_START || it.status_code == ST_RESTART) begin
              r.tx_valid       = 1'b1;
              r.tx_byte        = {chip, 1'b0};
              r.ctl_clear_flag = 1'b1;
            end else if (it.status_code == ST_SLAW_ACK || it.status_code == ST_TXDATA_ACK) begin
              if (pos < d.len && pos < MSG_BYTES) begin
                r.tx_valid       = 1'b1;
                r.tx_byte        = tx_mem[msg_idx][pos];
                r.ctl_clear_flag = 1'b1;
                pos++;
              end else begin
                next_message(r);
              end
            end else begin
              fail_sequence(r);
            end
          end
        end
      end
    endcase
    expected_actions.push_back(r);
    return 1'b1;
  endfunction

  function void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_actions.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %0h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_actions.pop_front();
    cmp_field("ctl_start", want.ctl_start, got.ctl_start);
    cmp_field("ctl_stop", want.ctl_stop, got.ctl_stop);
    cmp_field("ctl_ack", want.ctl_ack, got.ctl_ack);
    cmp_field("ctl_clear_flag", want.ctl_clear_flag, got.ctl_clear_flag);
    cmp_field("tx_valid", want.tx_valid, got.tx_valid);
    cmp_field("tx_byte", want.tx_byte, got.tx_byte);
    cmp_field("rx_valid", want.rx_valid, got.rx_valid);
    cmp_field("rx_msg", want.rx_msg, got.rx_msg);
    cmp_field("rx_pos", want.rx_pos, got.rx_pos);
    cmp_field("rx_byte", want.rx_byte, got.rx_byte);
    cmp_field("outcome", want.outcome, got.outcome);
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 650;
  localparam int HOLD_CYCLES = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = OP_LOAD_DESC;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  seq_action_scoreboard sb = new();

  // Idle percentages, moved through the three phases by the stimulus
  int tx_idle_pct = 20;
  int rx_idle_pct = 81;

  int  useful_items = 0;  // accepted inputs that the block acts on
  int  cycles       = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  // Transmit bytes already loaded, so a write message never reads an empty entry
  bit  tx_written [8][256];

  i2c_master_transfer_sequencer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  // and pushes back on the input while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && useful_items >= 120) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [55:0] pack_item(item_t it);
    return {7'b0, it.timed_out, it.status_code, it.message_count, it.chip_address,
            it.data_byte, it.msg_length, it.is_read, it.byte_slot, it.msg_slot};
  endfunction

  function automatic item_t unpack_item(logic [1:0] op, logic [55:0] d);
    item_t it;
    it.op            = op_t'(op);
    it.msg_slot      = d[2:0];
    it.byte_slot     = d[10:3];
    it.is_read       = d[11];
    it.msg_length    = d[20:12];
    it.data_byte     = d[28:21];
    it.chip_address  = d[35:29];
    it.message_count = d[39:36];
    it.status_code   = d[47:40];
    it.timed_out     = d[48];
    return it;
  endfunction

  function automatic result_t unpack_result(logic [39:0] d);
    result_t r;
    r.ctl_start      = d[0];
    r.ctl_stop       = d[1];
    r.ctl_ack        = d[2];
    r.ctl_clear_flag = d[3];
    r.tx_valid       = d[4];
    r.tx_byte        = d[12:5];
    r.rx_valid       = d[13];
    r.rx_msg         = d[16:14];
    r.rx_pos         = d[24:17];
    r.rx_byte        = d[32:25];
    r.outcome        = d[34:33];
    return r;
  endfunction

  // Sample both channels on the edge; predict on input, check on output
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (sb.note_transfer(unpack_item(in_tuser, in_tdata))) useful_items++;
      end
      if (out_tvalid && out_tready) sb.check_result(unpack_result(out_tdata));
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    if (useful_items < 220) begin
      tx_idle_pct = 20;
      rx_idle_pct = 81;
    end else if (useful_items < 440) begin
      tx_idle_pct = 81;
      rx_idle_pct = 20;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= pack_item(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_tx(input int slot, input int p, input int b);
    item_t it;
    it           = '0;
    it.op        = OP_LOAD_TX;
    it.msg_slot  = slot[2:0];
    it.byte_slot = p[7:0];
    it.data_byte = b[7:0];
    tx_written[slot][p] = 1'b1;
    send_item(it);
  endtask

  // Load a descriptor; for a write, fill in any payload bytes it would reach
  task automatic load_desc(input int slot, input bit rd, input int len);
    item_t it;
    if (!rd) begin
      for (int p = 0; p < len && p < 256; p++)
        if (!tx_written[slot][p]) load_tx(slot, p, $urandom_range(255));
    end
    it            = '0;
    it.op         = OP_LOAD_DESC;
    it.msg_slot   = slot[2:0];
    it.is_read    = rd;
    it.msg_length = len[8:0];
    send_item(it);
  endtask

  task automatic start_sequence(input int addr, input int cnt);
    item_t it;
    it               = '0;
    it.op            = OP_START;
    it.chip_address  = addr[6:0];
    it.message_count = cnt[3:0];
    send_item(it);
  endtask

  task automatic bus_event(input int st, input bit tmo, input int b);
    item_t it;
    it             = '0;
    it.op          = OP_EVENT;
    it.status_code = st[7:0];
    it.timed_out   = tmo;
    it.data_byte   = b[7:0];
    send_item(it);
  endtask

  // Send the expected status, or now and then break the sequence instead
  task automatic step_event(input int st, input bit faults, output bit broke);
    broke = faults && ($urandom_range(99) < 3);
    if (!broke) begin
      bus_event(st, 1'b0, $urandom_range(255));
    end else begin
      case ($urandom_range(2))
        0:       bus_event(st, 1'b1, $urandom_range(255));
        1:       bus_event($urandom_range(255), $urandom_range(1), $urandom_range(255));
        default: start_sequence($urandom_range(127), $urandom_range(1, 8));
      endcase
    end
  endtask

  // Well-formed multi-message sequence with random content
  task automatic run_sequence(input bit long_read);
    bit rd  [8];
    int len [8];
    int n;
    bit broke;
    n = long_read ? 1 : (($urandom_range(99) < 70) ? $urandom_range(1, 3) : $urandom_range(1, 8));
    for (int i = 0; i < n; i++) begin
      rd[i] = long_read ? 1'b1 : 1'($urandom_range(1));
      if (long_read)  len[i] = $urandom_range(256, 511);
      else if (rd[i]) len[i] = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 6);
      else            len[i] = $urandom_range(0, 6);
      load_desc(i, rd[i], len[i]);
      if (len[i] > 256) len[i] = 256;
    end
    start_sequence($urandom_range(127), n);
    broke = 1'b0;
    for (int i = 0; i < n; i++) begin
      step_event((i == 0) ? ST_START : ST_RESTART, !long_read, broke);
      if (broke) break;
      if (rd[i]) begin
        step_event(ST_SLAR_ACK, !long_read, broke);
        if (broke || len[i] == 0) break;
        for (int k = 1; k < len[i] && !broke; k++) step_event(ST_RXDATA_ACK, !long_read, broke);
        // an extra acked byte takes the last position, and the NACK byte past the length gets dropped
        if (!broke && $urandom_range(99) < 10) step_event(ST_RXDATA_ACK, 1'b0, broke);
        if (!broke) step_event(ST_RXDATA_NACK, !long_read, broke);
      end else begin
        step_event(ST_SLAW_ACK, !long_read, broke);
        for (int k = 0; k < len[i] && !broke; k++) step_event(ST_TXDATA_ACK, !long_read, broke);
      end
      if (broke) break;
    end
  endtask

  // Unstructured traffic: any op with random fields
  task automatic noise_item();
    bit rd;
    int st;
    rd = $urandom_range(1);
    case ($urandom_range(3))
      0: load_desc($urandom_range(7), rd, rd ? $urandom_range(511) : $urandom_range(15));
      1: load_tx($urandom_range(7), $urandom_range(255), $urandom_range(255));
      2: start_sequence($urandom_range(127), $urandom_range(15));
      default: begin
        case ($urandom_range(8))
          0: st = ST_START;
          1: st = ST_RESTART;
          2: st = ST_SLAW_ACK;
          3: st = ST_TXDATA_ACK;
          4: st = ST_SLAR_ACK;
          5: st = ST_RXDATA_ACK;
          6: st = ST_RXDATA_NACK;
          default: st = $urandom_range(255);
        endcase
        bus_event(st, $urandom_range(99) < 10, $urandom_range(255));
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: write of two bytes, read of one, empty write, empty read
    load_desc(0, 1'b0, 2);
    load_desc(1, 1'b1, 1);
    load_desc(2, 1'b0, 0);
    load_desc(3, 1'b1, 0);
    // event with nothing running is ignored
    bus_event(ST_START, 1'b0, 8'hFF);
    // zero and oversized message counts are rejected
    start_sequence(7'h7F, 0);
    start_sequence(7'h7F, 9);
    // four messages joined by repeated starts, ending on the empty read
    start_sequence(7'h7F, 4);
    bus_event(ST_START, 1'b0, 8'h00);
    bus_event(ST_SLAW_ACK, 1'b0, 8'h00);
    bus_event(ST_TXDATA_ACK, 1'b0, 8'h00);
    bus_event(ST_TXDATA_ACK, 1'b0, 8'h00);
    bus_event(ST_RESTART, 1'b0, 8'h00);
    bus_event(ST_SLAR_ACK, 1'b0, 8'h00);
    bus_event(ST_RXDATA_ACK, 1'b0, 8'hA5);
    bus_event(ST_RXDATA_ACK, 1'b0, 8'h5A);  // beyond the length: dropped
    bus_event(ST_RXDATA_NACK, 1'b0, 8'hFF);
    bus_event(ST_RESTART, 1'b0, 8'h00);
    bus_event(ST_SLAW_ACK, 1'b0, 8'h00);
    bus_event(ST_RESTART, 1'b0, 8'h00);
    bus_event(ST_SLAR_ACK, 1'b0, 8'h00);    // zero-length read fails
    // a new start replaces a running sequence; then a timeout
    start_sequence(7'h00, 8);
    bus_event(ST_START, 1'b0, 8'h00);
    start_sequence(7'h15, 1);
    bus_event(ST_SLAW_ACK, 1'b1, 8'h00);
    // unknown status fails
    start_sequence(7'h3C, 1);
    bus_event(8'hF8, 1'b0, 8'h00);
    // oversized length saturates
    load_desc(4, 1'b1, 511);

    // Random: fill remaining descriptors, one long read, then the mix
    for (int s = 5; s < 8; s++) load_desc(s, $urandom_range(1), $urandom_range(0, 6));
    run_sequence(1'b1);
    while (useful_items < ITEM_TARGET) begin
      if ($urandom_range(99) < 70) run_sequence(1'b0);
      else repeat ($urandom_range(1, 6)) noise_item();
    end
    in_tvalid <= 1'b0;

    // Drain outstanding actions, then leave room for any stray result
    while (sb.expected_actions.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_actions.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
